/* rtl/afr_pkg.sv */
package afr_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'h77;
  localparam logic [7:0] LEN_ANGLE   = 8'h0D;
  localparam logic [7:0] LEN_ADDR    = 8'h04;
  localparam logic [7:0] ADDR_TAG    = 8'h1F;
  localparam logic [7:0] MIN_TOTAL   = 8'd3;
  localparam logic [7:0] TOTAL_RESET = 8'd14;
  // bytes kept for decoding: positions 3 .. 12 of a frame
  localparam int         BODY_LO     = 3;
  localparam int         BODY_HI     = 12;

  typedef logic signed [11:0] whole_t;
  typedef logic signed [15:0] frac_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ANGLE = 2'd1,
    KIND_ADDR  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       byte_kept;
    logic [7:0] byte_index;
    kind_t      frame_kind;
    logic [7:0] frame_length;
    logic       frame_pending;
    whole_t     x_whole;
    frac_t      x_fraction;
    whole_t     y_whole;
    frac_t      y_fraction;
    whole_t     z_whole;
    frac_t      z_fraction;
    logic [7:0] device_address;
  } result_t;

endpackage

/* rtl/afr_in_if.sv */
interface afr_in_if;
  import afr_pkg::*;

  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

/* rtl/afr_out_if.sv */
interface afr_out_if;
  import afr_pkg::*;

  logic       valid;
  logic       ready;
  logic       byte_kept;
  logic [7:0] byte_index;
  kind_t      frame_kind;
  logic [7:0] frame_length;
  logic       frame_pending;
  whole_t     x_whole;
  frac_t      x_fraction;
  whole_t     y_whole;
  frac_t      y_fraction;
  whole_t     z_whole;
  frac_t      z_fraction;
  logic [7:0] device_address;

  modport source (
    output valid, input ready,
    output byte_kept, output byte_index, output frame_kind, output frame_length,
    output frame_pending, output x_whole, output x_fraction, output y_whole,
    output y_fraction, output z_whole, output z_fraction, output device_address
  );
  modport sink (
    input valid, output ready,
    input byte_kept, input byte_index, input frame_kind, input frame_length,
    input frame_pending, input x_whole, input x_fraction, input y_whole,
    input y_fraction, input z_whole, input z_fraction, input device_address
  );
endinterface

/* rtl/afr_angle_dec.sv */
module afr_angle_dec (
  input  logic [7:0]      a,
  input  logic [7:0]      b,
  input  logic [7:0]      c,
  output afr_pkg::whole_t whole,
  output afr_pkg::frac_t  frac
);
  import afr_pkg::*;

  logic [10:0] mag_w;
  logic [14:0] mag_f;
  logic        neg;

  // digits are not range-checked: nibbles above 9 weigh in as they are
  assign mag_w = 11'(a[3:0]) * 11'd100 + 11'(b[7:4]) * 11'd10 + 11'(b[3:0]);
  assign mag_f = 15'(c[7:4]) * 15'd1000 + 15'(c[3:0]) * 15'd100;
  assign neg   = (a[7:4] != 4'd0);

  assign whole = neg ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
  assign frac  = neg ? -$signed({1'b0, mag_f}) : $signed({1'b0, mag_f});
endmodule

/* rtl/afr_core.sv */
module afr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  afr_pkg::in_item_t item,
  output afr_pkg::result_t  res
);
  import afr_pkg::*;

  logic [7:0] cnt, cnt_next;
  logic [7:0] total, total_next;
  logic       pend, pend_next;
  logic [7:0] len_byte;
  logic [7:0] addr, addr_next;
  logic [7:0] body [BODY_LO:BODY_HI];

  logic [7:0] cnt_eff;
  logic [7:0] len_plus;
  logic       len_wr;
  logic       body_wr;
  logic       kept;
  kind_t      kind;

  whole_t xw, yw, zw;
  frac_t  xf, yf, zf;

  afr_angle_dec u_x (.a(body[4]),  .b(body[5]),  .c(body[6]),  .whole(xw), .frac(xf));
  afr_angle_dec u_y (.a(body[7]),  .b(body[8]),  .c(body[9]),  .whole(yw), .frac(yf));
  afr_angle_dec u_z (.a(body[10]), .b(body[11]), .c(body[12]), .whole(zw), .frac(zf));

  assign cnt_eff  = (cnt == total) ? 8'd0 : cnt;
  assign len_plus = item.data_byte + 8'd1;

  always_comb begin
    cnt_next   = cnt;
    total_next = total;
    pend_next  = pend;
    addr_next  = addr;
    len_wr     = 1'b0;
    body_wr    = 1'b0;
    kept       = 1'b0;
    kind       = KIND_NONE;
    if (item.mode) begin
      pend_next = 1'b0;
    end else if (!pend) begin
      cnt_next = cnt_eff;
      if (cnt_eff == 8'd0) begin
        // drop anything but a header at the start of a frame
        if (item.data_byte == HDR_BYTE) begin
          kept     = 1'b1;
          cnt_next = 8'd1;
        end
      end else if (cnt_eff == 8'd1) begin
        len_wr     = 1'b1;
        kept       = 1'b1;
        cnt_next   = 8'd2;
        total_next = (len_plus < MIN_TOTAL) ? MIN_TOTAL : len_plus;
      end else if (cnt_eff < total) begin
        kept     = 1'b1;
        body_wr  = (cnt_eff >= 8'(BODY_LO)) && (cnt_eff <= 8'(BODY_HI));
        cnt_next = cnt_eff + 8'd1;
        if (cnt_next == total) begin
          pend_next = 1'b1;
          if (len_byte == LEN_ANGLE) begin
            kind = KIND_ANGLE;
          end else if (len_byte == LEN_ADDR && body[3] == ADDR_TAG) begin
            // address byte is the last byte of the frame, the one arriving now
            kind      = KIND_ADDR;
            addr_next = item.data_byte;
          end else begin
            kind = KIND_OTHER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= 8'd0;
      total <= TOTAL_RESET;
      pend  <= 1'b0;
      addr  <= 8'd0;
    end else if (step) begin
      cnt   <= cnt_next;
      total <= total_next;
      pend  <= pend_next;
      addr  <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && len_wr) begin
      len_byte <= item.data_byte;
    end
    if (step && body_wr) begin
      body[cnt_eff[3:0]] <= item.data_byte;
    end
  end

  always_comb begin
    res                = '0;
    res.byte_kept      = kept;
    res.byte_index     = kept ? cnt_eff : 8'd0;
    res.frame_kind     = kind;
    res.frame_length   = total_next;
    res.frame_pending  = pend_next;
    res.device_address = addr_next;
    if (kind == KIND_ANGLE) begin
      res.x_whole    = xw;
      res.x_fraction = xf;
      res.y_whole    = yw;
      res.y_fraction = yf;
      res.z_whole    = zw;
      res.z_fraction = zf;
    end
  end
endmodule

/* rtl/angle_frame_receiver.sv */
// channel | dir | payload                                  | handshake
// rx      | in  | mode, data_byte                          | valid/ready
// report  | out | byte_kept .. device_address (one a word) | valid/ready
//
// One word per cycle sustained while report is not stalled; a taken word
// goes input register, framing logic, result register, then out on report.
// The framing state advances as a word moves from the input register into
// the result register, so a stalled report holds the input register and
// then drops rx.ready. Reset clears the byte counter, flags and the address
// latch and sets the frame length to 14; stored frame bytes are left as they are.
module angle_frame_receiver (
  input  logic clk,
  input  logic rst,
  afr_in_if.sink    rx,
  afr_out_if.source report
);
  import afr_pkg::*;

  in_item_t rx_item;
  logic     rx_full;
  result_t  res_comb;
  result_t  res_q;
  logic     res_full;
  logic     advance;

  assign advance  = rx_full && (!res_full || report.ready);
  assign rx.ready = !rx_full || advance;

  afr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (rx_item),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_full  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        rx_full <= 1'b1;
      end else if (advance) begin
        rx_full <= 1'b0;
      end
      if (advance) begin
        res_full <= 1'b1;
      end else if (report.ready) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      rx_item.mode      <= rx.mode;
      rx_item.data_byte <= rx.data_byte;
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign report.valid          = res_full;
  assign report.byte_kept      = res_q.byte_kept;
  assign report.byte_index     = res_q.byte_index;
  assign report.frame_kind     = res_q.frame_kind;
  assign report.frame_length   = res_q.frame_length;
  assign report.frame_pending  = res_q.frame_pending;
  assign report.x_whole        = res_q.x_whole;
  assign report.x_fraction     = res_q.x_fraction;
  assign report.y_whole        = res_q.y_whole;
  assign report.y_fraction     = res_q.y_fraction;
  assign report.z_whole        = res_q.z_whole;
  assign report.z_fraction     = res_q.z_fraction;
  assign report.device_address = res_q.device_address;
endmodule

/* rtl/afr_checker.sv */
module afr_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        byte_kept,
  input logic [7:0]  byte_index,
  input logic [1:0]  frame_kind,
  input logic        frame_pending,
  input logic [11:0] x_whole,
  input logic [15:0] x_fraction,
  input logic [11:0] y_whole,
  input logic [15:0] y_fraction,
  input logic [11:0] z_whole,
  input logic [15:0] z_fraction
);
  import afr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) && $stable(byte_index))
    else $error("report word changed while stalled");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_NONE |-> frame_pending && byte_kept)
    else $error("completed frame without pending flag or kept byte");

  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_kept |-> byte_index == 8'd0)
    else $error("index given for a dropped byte");

  a_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_ANGLE |->
      x_whole == 12'd0 && x_fraction == 16'd0 && y_whole == 12'd0 &&
      y_fraction == 16'd0 && z_whole == 12'd0 && z_fraction == 16'd0)
    else $error("angle fields set outside an angle frame");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && rx_ready)
    else $error("pipeline not empty after reset");
endmodule

bind angle_frame_receiver afr_checker u_afr_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx.ready),
  .out_valid     (report.valid),
  .out_ready     (report.ready),
  .byte_kept     (report.byte_kept),
  .byte_index    (report.byte_index),
  .frame_kind    (report.frame_kind),
  .frame_pending (report.frame_pending),
  .x_whole       (report.x_whole),
  .x_fraction    (report.x_fraction),
  .y_whole       (report.y_whole),
  .y_fraction    (report.y_fraction),
  .z_whole       (report.z_whole),
  .z_fraction    (report.z_fraction)
);

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import afr_pkg::*;

  logic clk;
  logic rst;

  afr_in_if  rx_ch ();
  afr_out_if rep_ch ();

  angle_frame_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .report (rep_ch)
  );

  // words waiting to be offered, and reports the framer should produce
  in_item_t rx_backlog [$];
  result_t  expected_reports [$];

  // framer state as this side sees it
  logic [7:0] frm_count;
  logic [7:0] frm_total;
  logic       frm_pending;
  logic [7:0] frm_bytes [13];
  logic [7:0] dev_addr;

  int  gen_count;
  int  words_sent;
  int  hold_left;
  bit  held;
  bit  rx_fire;
  int  errors;
  int  mismatches;
  int  reports_seen;
  in_item_t seen_word;
  in_item_t next_word;
  result_t  got;
  result_t  want;
  string    diff;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // signed BCD angle from three consecutive frame bytes
  function automatic void bcd_angle(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c, output whole_t w, output frac_t f);
    int wi;
    int fi;
    wi = a[3:0] * 100 + b[7:4] * 10 + b[3:0];
    fi = c[7:4] * 1000 + c[3:0] * 100;
    if (a[7:4] != 4'd0) begin
      wi = -wi;
      fi = -fi;
    end
    w = wi[11:0];
    f = fi[15:0];
  endfunction

  function automatic result_t frame_step(input in_item_t it);
    result_t    r;
    logic [7:0] t;
    r = '0;
    if (it.mode) begin
      frm_pending = 1'b0;
    end else if (!frm_pending) begin
      if (frm_count == frm_total) frm_count = 8'd0;
      if (frm_count == 8'd0) begin
        if (it.data_byte == HDR_BYTE) begin
          frm_bytes[0] = it.data_byte;
          r.byte_kept = 1'b1;
          frm_count = 8'd1;
        end
      end else if (frm_count == 8'd1) begin
        frm_bytes[1] = it.data_byte;
        t = it.data_byte + 8'd1;
        if (t < MIN_TOTAL) t = MIN_TOTAL;
        frm_total = t;
        r.byte_kept = 1'b1;
        r.byte_index = 8'd1;
        frm_count = 8'd2;
      end else if (frm_count < frm_total) begin
        if (frm_count < 8'd13) frm_bytes[frm_count] = it.data_byte;
        r.byte_kept = 1'b1;
        r.byte_index = frm_count;
        frm_count = frm_count + 8'd1;
        if (frm_count == frm_total) begin
          frm_pending = 1'b1;
          if (frm_bytes[1] == LEN_ANGLE) begin
            r.frame_kind = KIND_ANGLE;
            bcd_angle(frm_bytes[4], frm_bytes[5], frm_bytes[6], r.x_whole, r.x_fraction);
            bcd_angle(frm_bytes[7], frm_bytes[8], frm_bytes[9], r.y_whole, r.y_fraction);
            bcd_angle(frm_bytes[10], frm_bytes[11], frm_bytes[12], r.z_whole, r.z_fraction);
          end else if (frm_bytes[1] == LEN_ADDR && frm_bytes[3] == ADDR_TAG) begin
            r.frame_kind = KIND_ADDR;
            dev_addr = frm_bytes[4];
          end else begin
            r.frame_kind = KIND_OTHER;
          end
        end
      end
    end
    r.frame_length = frm_total;
    r.frame_pending = frm_pending;
    r.device_address = dev_addr;
    return r;
  endfunction

  task automatic push_word(input logic m, input logic [7:0] d, input bit counted);
    in_item_t w;
    w.mode = m;
    w.data_byte = d;
    rx_backlog.push_back(w);
    if (counted) gen_count++;
  endtask

  task automatic send_ack();
    push_word(1'b1, 8'($urandom_range(255)), 1'b1);
  endtask

  // header, length, two filler bytes, x/y/z triplets, one trailing byte
  task automatic send_angle(input logic [23:0] xb, input logic [23:0] yb,
                            input logic [23:0] zb);
    int i;
    push_word(1'b0, HDR_BYTE, 1'b1);
    push_word(1'b0, LEN_ANGLE, 1'b1);
    push_word(1'b0, 8'($urandom_range(255)), 1'b1);
    push_word(1'b0, 8'($urandom_range(255)), 1'b1);
    for (i = 2; i >= 0; i--) push_word(1'b0, xb[i*8 +: 8], 1'b1);
    for (i = 2; i >= 0; i--) push_word(1'b0, yb[i*8 +: 8], 1'b1);
    for (i = 2; i >= 0; i--) push_word(1'b0, zb[i*8 +: 8], 1'b1);
    push_word(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_addr(input logic [7:0] tag, input logic [7:0] address);
    push_word(1'b0, HDR_BYTE, 1'b1);
    push_word(1'b0, LEN_ADDR, 1'b1);
    push_word(1'b0, 8'($urandom_range(255)), 1'b1);
    push_word(1'b0, tag, 1'b1);
    push_word(1'b0, address, 1'b1);
  endtask

  // mostly a decimal digit, now and then any nibble
  function automatic logic [3:0] digit();
    logic [3:0] n;
    if ($urandom_range(9) == 0) n = 4'($urandom_range(15));
    else n = 4'($urandom_range(9));
    return n;
  endfunction

  function automatic logic [23:0] angle_bytes();
    logic [3:0] s;
    if ($urandom_range(1) == 0) s = 4'd0;
    else s = 4'($urandom_range(15, 1));
    return {s, digit(), digit(), digit(), digit(), digit()};
  endfunction

  function automatic bit idle_roll();
    bit calm;
    calm = (words_sent >= 120 && words_sent < 240);
    return !calm && ($urandom_range(99) < 16);
  endfunction

  // sender: offer a new word once the last one is taken
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (rx_fire || !rx_ch.valid) begin
      if (rx_backlog.size() != 0 && !idle_roll()) begin
        next_word = rx_backlog.pop_front();
        rx_ch.valid <= 1'b1;
        rx_ch.mode <= next_word.mode;
        rx_ch.data_byte <= next_word.data_byte;
        words_sent <= words_sent + 1;
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      rep_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rep_ch.ready <= 1'b0;
    end else if (words_sent >= 330 && !held) begin
      held <= 1'b1;
      hold_left <= 80;
      rep_ch.ready <= 1'b0;
    end else begin
      rep_ch.ready <= !idle_roll();
    end
  end

  always @(posedge clk) begin
    rx_fire <= !rst && rx_ch.valid && rx_ch.ready;
    if (!rst && rx_ch.valid && rx_ch.ready) begin
      seen_word.mode = rx_ch.mode;
      seen_word.data_byte = rx_ch.data_byte;
      expected_reports.push_back(frame_step(seen_word));
    end
    if (!rst && rep_ch.valid && rep_ch.ready) begin
      got.byte_kept = rep_ch.byte_kept;
      got.byte_index = rep_ch.byte_index;
      got.frame_kind = rep_ch.frame_kind;
      got.frame_length = rep_ch.frame_length;
      got.frame_pending = rep_ch.frame_pending;
      got.x_whole = rep_ch.x_whole;
      got.x_fraction = rep_ch.x_fraction;
      got.y_whole = rep_ch.y_whole;
      got.y_fraction = rep_ch.y_fraction;
      got.z_whole = rep_ch.z_whole;
      got.z_fraction = rep_ch.z_fraction;
      got.device_address = rep_ch.device_address;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d arrived with nothing outstanding", reports_seen);
      end else begin
        want = expected_reports.pop_front();
        diff = "";
        if (got.byte_kept !== want.byte_kept) diff = {diff, " byte_kept"};
        if (got.byte_index !== want.byte_index) diff = {diff, " byte_index"};
        if (got.frame_kind !== want.frame_kind) diff = {diff, " frame_kind"};
        if (got.frame_length !== want.frame_length) diff = {diff, " frame_length"};
        if (got.frame_pending !== want.frame_pending) diff = {diff, " frame_pending"};
        if (got.x_whole !== want.x_whole) diff = {diff, " x_whole"};
        if (got.x_fraction !== want.x_fraction) diff = {diff, " x_fraction"};
        if (got.y_whole !== want.y_whole) diff = {diff, " y_whole"};
        if (got.y_fraction !== want.y_fraction) diff = {diff, " y_fraction"};
        if (got.z_whole !== want.z_whole) diff = {diff, " z_whole"};
        if (got.z_fraction !== want.z_fraction) diff = {diff, " z_fraction"};
        if (got.device_address !== want.device_address) diff = {diff, " device_address"};
        if (diff != "") begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("report %0d differs in%s", reports_seen, diff);
            $display("  expected kept=%0d idx=%0d kind=%0d len=%0d pend=%0d",
                     want.byte_kept, want.byte_index, want.frame_kind,
                     want.frame_length, want.frame_pending);
            $display("    x=%0d/%0d y=%0d/%0d z=%0d/%0d addr=%02h",
                     want.x_whole, want.x_fraction, want.y_whole, want.y_fraction,
                     want.z_whole, want.z_fraction, want.device_address);
            $display("  actual   kept=%0d idx=%0d kind=%0d len=%0d pend=%0d",
                     got.byte_kept, got.byte_index, got.frame_kind,
                     got.frame_length, got.frame_pending);
            $display("    x=%0d/%0d y=%0d/%0d z=%0d/%0d addr=%02h",
                     got.x_whole, got.x_fraction, got.y_whole, got.y_fraction,
                     got.z_whole, got.z_fraction, got.device_address);
          end
        end
      end
    end
  end

  initial begin
    #200000;
    $display("[angle_frame_receiver] ERROR");
    $finish;
  end

  initial begin
    int         pick;
    int         n;
    int         i;
    logic [7:0] len;
    logic [7:0] tot;

    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.mode = 1'b0;
    rx_ch.data_byte = 8'd0;
    rep_ch.ready = 1'b0;
    frm_count = 8'd0;
    frm_total = TOTAL_RESET;
    frm_pending = 1'b0;
    dev_addr = 8'd0;
    gen_count = 0;
    words_sent = 0;
    hold_left = 0;
    held = 1'b0;
    rx_fire = 1'b0;
    errors = 0;
    mismatches = 0;
    reports_seen = 0;

    // acknowledge with nothing pending, then bytes dropped at position 0
    push_word(1'b1, 8'hFF, 1'b1);
    push_word(1'b0, 8'h00, 1'b1);
    push_word(1'b0, 8'hFF, 1'b1);
    // largest decimal x, all-ones y (nibbles above nine), negative zero z
    send_angle(24'h099999, 24'hFFFFFF, 24'h100000);
    push_word(1'b0, HDR_BYTE, 1'b1);
    send_ack();
    send_addr(ADDR_TAG, 8'hA5);
    send_ack();
    // length byte that wraps to zero and is clamped
    push_word(1'b0, HDR_BYTE, 1'b1);
    push_word(1'b0, 8'hFF, 1'b1);
    push_word(1'b0, 8'h00, 1'b1);
    send_ack();

    // noise words are not counted here, so stop short of the word budget
    while (gen_count < 410) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_angle(angle_bytes(), angle_bytes(), angle_bytes());
      end else if (pick < 60) begin
        if ($urandom_range(4) == 0)
          send_addr(8'($urandom_range(255)), 8'($urandom_range(255)));
        else send_addr(ADDR_TAG, 8'($urandom_range(255)));
      end else if (pick < 80) begin
        if ($urandom_range(19) == 0) len = 8'($urandom_range(255));
        else len = 8'($urandom_range(20));
        tot = len + 8'd1;
        if (tot < MIN_TOTAL) tot = MIN_TOTAL;
        push_word(1'b0, HDR_BYTE, 1'b1);
        push_word(1'b0, len, 1'b1);
        for (i = 2; i < tot; i++) push_word(1'b0, 8'($urandom_range(255)), 1'b1);
      end else if (pick < 90) begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) push_word(1'b0, 8'($urandom_range(255)), 1'b0);
      end else begin
        // frame cut short: whatever follows is swallowed into it
        push_word(1'b0, HDR_BYTE, 1'b0);
        n = $urandom_range(5);
        for (i = 0; i < n; i++) push_word(1'b0, 8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(9) < 3) begin
        n = $urandom_range(3, 1);
        for (i = 0; i < n; i++) push_word(1'b0, 8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(9) != 0) send_ack();
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (rx_backlog.size() != 0 || rx_ch.valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_reports.size() != 0) errors++;

    if (errors == 0) begin
      $display("[angle_frame_receiver] OK");
    end else begin
      $display("[angle_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule
